// File: rtl/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

	localparam int unsigned HEAP_DEPTH_DEF = 4096;
	localparam int unsigned TYPE_COUNT_DEF = 16;

	localparam logic [15:0] NULL_RUN = 16'hFFFF;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] REG_BLOCK_LOG2 = 2'd0;
	localparam logic [1:0] REG_HEAP_BLOCKS = 2'd1;
	localparam logic [1:0] REG_FIXED_TYPE = 2'd2;

	localparam logic [2:0]  RST_BLOCK_LOG2 = 3'd2;
	localparam logic [15:0] RST_HEAP_BLOCKS = 16'd4096;
	localparam logic [3:0]  RST_FIXED_TYPE = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_A_CHK,
		ST_A_EVAL,
		ST_A_HDR,
		ST_F_HDR,
		ST_F_ECHK,
		ST_F_CHK,
		ST_F_EVAL,
		ST_F_OVL,
		ST_F_WP,
		ST_F_WPREV,
		ST_DONE,
		ST_FAIL
	} state_t;

	typedef struct packed {
		logic latch;
		logic walk_init;
		logic rd_cur;
		logic rd_p;
		logic step;
		logic ld_flen_calc;
		logic ld_flen_hdr;
		logic a_commit;
		logic a_hdr;
		logic f_wp;
		logic f_wprev;
	} dp_cmd_t;

	typedef struct packed {
		logic type_bad;
		logic is_free;
		logic is_fixed;
		logic blk_zero;
		logic p_oob;
		logic end_oob;
		logic cur_valid;
		logic steps_ok;
		logic cur_eq_p;
		logic cur_gt_p;
		logic fit;
		logic prev_overlap;
		logic cur_overlap;
	} dp_stat_t;

	function automatic logic [15:0] inc_sat(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [15:0] dec_sat(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? (a - b) : 16'd0;
	endfunction

endpackage
`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Ports                                           | Handshake
// ----------+-------------------------------------------------+-------------------------
// request   | cmd, size_bytes, mem_type, release_block        | start high, busy low
// result    | status, granted_block, free_block_total,        | done high for one cycle
//           | live_total, type_live, type_used_blocks         |
// config    | cfg_we, cfg_idx, cfg_data                       | cfg_we high, no wait
//
// One request at a time. Allocate walks the free runs to the first that fits, then
// writes a header for the fixed type. Free reads that header, walks the runs before
// the freed one and writes it and its predecessor. The walk uses the single read port.
// Reset (and a heap geometry write) leaves one free run at block 0 with no memory
// sweep; entry 0 is flagged until first written. Results cannot be stalled.
module first_fit_block_allocator import ffa_pkg::*; #(
	parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
	parameter int unsigned TYPE_COUNT = TYPE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [15:0] size_bytes,
	input  wire logic [3:0]  mem_type,
	input  wire logic [15:0] release_block,
	output logic             done,
	output logic             status,
	output logic [15:0]      granted_block,
	output logic [15:0]      free_block_total,
	output logic [15:0]      live_total,
	output logic [15:0]      type_live,
	output logic [15:0]      type_used_blocks
);

	dp_cmd_t     dcmd;
	dp_stat_t    dstat;
	logic        fail;
	logic [15:0] granted;

	// sequencer: list walk, checks and commit order
	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dstat),
		.cmd    (dcmd),
		.busy   (busy),
		.done   (done),
		.fail   (fail)
	);

	// free list store, counters and config registers
	ffa_dp #(
		.HEAP_DEPTH (HEAP_DEPTH),
		.TYPE_COUNT (TYPE_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd_in   (cmd),
		.size_in  (size_bytes),
		.type_in  (mem_type),
		.blk_in   (release_block),
		.cmd      (dcmd),
		.stat     (dstat),
		.granted  (granted),
		.free_tot (free_block_total),
		.live_tot (live_total),
		.t_live   (type_live),
		.t_blocks (type_used_blocks)
	);

	// a refused request reports no block
	assign status = fail;
	assign granted_block = fail ? NULL_RUN : granted;

endmodule
`default_nettype wire

// File: rtl/ffa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done,
	output logic          fail
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE) || (state_q == ST_FAIL);
		fail = (state_q == ST_FAIL);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.type_bad) begin
					state_d = ST_FAIL;
				end else if (!stat.is_free) begin
					cmd.walk_init = 1'b1;
					state_d = ST_A_CHK;
				end else if (stat.is_fixed) begin
					if (stat.blk_zero || stat.p_oob) begin
						state_d = ST_FAIL;
					end else begin
						cmd.rd_p = 1'b1;
						state_d = ST_F_HDR;
					end
				end else if (stat.p_oob) begin
					state_d = ST_FAIL;
				end else begin
					cmd.ld_flen_calc = 1'b1;
					state_d = ST_F_ECHK;
				end
			end
			ST_A_CHK: begin
				if (stat.cur_valid && stat.steps_ok) begin
					cmd.rd_cur = 1'b1;
					state_d = ST_A_EVAL;
				end else begin
					state_d = ST_FAIL;
				end
			end
			ST_A_EVAL: begin
				if (stat.fit) begin
					cmd.a_commit = 1'b1;
					state_d = stat.is_fixed ? ST_A_HDR : ST_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d = ST_A_CHK;
				end
			end
			ST_A_HDR: begin
				cmd.a_hdr = 1'b1;
				state_d = ST_DONE;
			end
			ST_F_HDR: begin
				cmd.ld_flen_hdr = 1'b1;
				state_d = ST_F_ECHK;
			end
			ST_F_ECHK: begin
				if (stat.end_oob) begin
					state_d = ST_FAIL;
				end else begin
					cmd.walk_init = 1'b1;
					state_d = ST_F_CHK;
				end
			end
			ST_F_CHK: begin
				if (stat.cur_valid && stat.steps_ok) begin
					if (stat.cur_eq_p) begin
						state_d = ST_FAIL;
					end else if (stat.cur_gt_p) begin
						state_d = ST_F_OVL;
					end else begin
						cmd.rd_cur = 1'b1;
						state_d = ST_F_EVAL;
					end
				end else begin
					state_d = ST_F_OVL;
				end
			end
			ST_F_EVAL: begin
				cmd.step = 1'b1;
				state_d = ST_F_CHK;
			end
			ST_F_OVL: begin
				if (stat.prev_overlap || (stat.cur_valid && stat.cur_overlap)) begin
					state_d = ST_FAIL;
				end else begin
					cmd.rd_cur = stat.cur_valid;
					state_d = ST_F_WP;
				end
			end
			ST_F_WP: begin
				cmd.f_wp = 1'b1;
				state_d = ST_F_WPREV;
			end
			ST_F_WPREV: begin
				cmd.f_wprev = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			ST_FAIL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/ffa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ffa_dp import ffa_pkg::*; #(
	parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
	parameter int unsigned TYPE_COUNT = TYPE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	input  wire logic        cmd_in,
	input  wire logic [15:0] size_in,
	input  wire logic [3:0]  type_in,
	input  wire logic [15:0] blk_in,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	output logic [15:0]      granted,
	output logic [15:0]      free_tot,
	output logic [15:0]      live_tot,
	output logic [15:0]      t_live,
	output logic [15:0]      t_blocks
);

	localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int unsigned TW = $clog2(TYPE_COUNT);
	localparam logic [16:0] DEPTH_LIM = (HEAP_DEPTH > 65534) ? 17'd65534 : 17'(HEAP_DEPTH);
	localparam logic [16:0] STEP_MAX = 17'(HEAP_DEPTH);
	localparam logic [15:0] RST_H = ({1'b0, RST_HEAP_BLOCKS} > DEPTH_LIM) ?
		DEPTH_LIM[15:0] : RST_HEAP_BLOCKS;

	logic [15:0] next_mem [HEAP_DEPTH];
	logic [15:0] len_mem [HEAP_DEPTH];

	logic [2:0]  lg_q;
	logic [15:0] hb_q;
	logic [3:0]  ft_q;

	logic        cmd_q;
	logic [15:0] size_q, blk_q;
	logic [3:0]  type_q;
	logic [15:0] flen_q, cur_q, prev_q, prev_len_q, got_q, granted_q, pn_q, pl_q, head_q;
	logic [16:0] steps_q;
	logic [15:0] free_q, live_q;
	logic [15:0] tlive_q [TYPE_COUNT];
	logic [15:0] tblk_q [TYPE_COUNT];

	logic        n0_q, l0_q, ovr_n_q, ovr_l_q;
	logic [15:0] rdn_raw_q, rdl_raw_q;

	logic [15:0] hsz, bf, need, p, rd_next, rd_len, link;
	logic [16:0] bsum;
	logic        is_fixed, prev_null, merge_cur, merge_prev, restart, type_bad;
	logic [15:0] h_new;
	logic [16:0] hb_new;
	logic [TW-1:0] tix;

	logic        rd_en, wn_en, wl_en;
	logic [AW-1:0] rd_addr, w_addr;
	logic [15:0] wn_d, wl_d;

	// heap size in force, clamped to the store
	assign hsz = ({1'b0, hb_q} > DEPTH_LIM) ? DEPTH_LIM[15:0] : hb_q;

	always_comb begin
		hb_new = {1'b0, (cfg_idx == REG_HEAP_BLOCKS) ? cfg_data : hb_q};
		h_new = (hb_new > DEPTH_LIM) ? DEPTH_LIM[15:0] : hb_new[15:0];
	end
	assign restart = cfg_we && ((cfg_idx == REG_BLOCK_LOG2) || (cfg_idx == REG_HEAP_BLOCKS));

	// bytes rounded up to blocks of 4 to 16 bytes (block size clamped), zero counts as one
	always_comb begin
		logic [16:0] sh;
		bsum = '0;
		sh = '0;
		case (lg_q)
			3'd0, 3'd1, 3'd2: begin
				bsum = {1'b0, size_q} + 17'd3;
				sh = bsum >> 2;
			end
			3'd3: begin
				bsum = {1'b0, size_q} + 17'd7;
				sh = bsum >> 3;
			end
			default: begin
				bsum = {1'b0, size_q} + 17'd15;
				sh = bsum >> 4;
			end
		endcase
		bf = (sh == 17'd0) ? 16'd1 : sh[15:0];
	end

	assign is_fixed = (type_q == ft_q);
	assign type_bad = ({28'd0, type_q} >= 32'(TYPE_COUNT));
	assign tix = type_q[TW-1:0];
	assign need = bf + {15'd0, is_fixed};
	assign p = is_fixed ? (blk_q - 16'd1) : blk_q;

	assign rd_next = ovr_n_q ? NULL_RUN : rdn_raw_q;
	assign rd_len = ovr_l_q ? hsz : rdl_raw_q;
	assign link = (rd_next < hsz) ? rd_next : NULL_RUN;
	assign prev_null = (prev_q == NULL_RUN);
	assign merge_cur = stat.cur_valid && (({1'b0, p} + {1'b0, flen_q}) == {1'b0, cur_q});
	assign merge_prev = !prev_null && (({1'b0, prev_q} + {1'b0, prev_len_q}) == {1'b0, p});

	always_comb begin
		stat.type_bad = type_bad;
		stat.is_free = (cmd_q == CMD_FREE);
		stat.is_fixed = is_fixed;
		stat.blk_zero = (blk_q == 16'd0);
		stat.p_oob = (p >= hsz);
		stat.end_oob = ({1'b0, p} + {1'b0, flen_q}) > {1'b0, hsz};
		stat.cur_valid = (cur_q < hsz);
		stat.steps_ok = (steps_q <= STEP_MAX);
		stat.cur_eq_p = (cur_q == p);
		stat.cur_gt_p = (cur_q > p);
		stat.fit = (rd_len >= need);
		stat.prev_overlap = !prev_null && (({1'b0, prev_q} + {1'b0, prev_len_q}) > {1'b0, p});
		stat.cur_overlap = ({1'b0, p} + {1'b0, flen_q}) > {1'b0, cur_q};
	end

	// memory port control
	always_comb begin
		rd_en = cmd.rd_cur || cmd.rd_p;
		rd_addr = cmd.rd_p ? p[AW-1:0] : cur_q[AW-1:0];
		wn_en = 1'b0;
		wl_en = 1'b0;
		w_addr = cur_q[AW-1:0];
		wn_d = NULL_RUN;
		wl_d = '0;
		if (cmd.a_commit) begin
			if (rd_len == need) begin
				wn_en = !prev_null;
				w_addr = prev_q[AW-1:0];
				wn_d = link;
			end else begin
				wl_en = 1'b1;
				wl_d = rd_len - need;
			end
		end else if (cmd.a_hdr) begin
			wn_en = 1'b1;
			wl_en = 1'b1;
			w_addr = got_q[AW-1:0];
			wl_d = need;
		end else if (cmd.f_wp) begin
			wn_en = 1'b1;
			wl_en = 1'b1;
			w_addr = p[AW-1:0];
			wn_d = merge_cur ? rd_next : (stat.cur_valid ? cur_q : NULL_RUN);
			wl_d = merge_cur ? (flen_q + rd_len) : flen_q;
		end else if (cmd.f_wprev) begin
			wn_en = !prev_null;
			wl_en = merge_prev;
			w_addr = prev_q[AW-1:0];
			wn_d = merge_prev ? pn_q : p;
			wl_d = prev_len_q + pl_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wn_en) next_mem[w_addr] <= wn_d;
		if (wl_en) len_mem[w_addr] <= wl_d;
		if (rd_en) begin
			rdn_raw_q <= next_mem[rd_addr];
			rdl_raw_q <= len_mem[rd_addr];
		end
	end

	// entry 0 stands for the initial single run until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n0_q <= 1'b1;
			l0_q <= 1'b1;
			ovr_n_q <= 1'b0;
			ovr_l_q <= 1'b0;
		end else begin
			if (restart) begin
				n0_q <= 1'b1;
				l0_q <= 1'b1;
			end else begin
				if (wn_en && (w_addr == '0)) n0_q <= 1'b0;
				if (wl_en && (w_addr == '0)) l0_q <= 1'b0;
			end
			if (rd_en) begin
				ovr_n_q <= n0_q && (rd_addr == '0);
				ovr_l_q <= l0_q && (rd_addr == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= cmd_in;
			size_q <= size_in;
			type_q <= type_in;
			blk_q <= blk_in;
		end
		if (cmd.ld_flen_calc) flen_q <= bf;
		if (cmd.ld_flen_hdr) flen_q <= (rd_len == 16'd0) ? 16'd1 : rd_len;
		if (cmd.walk_init) begin
			cur_q <= head_q;
			prev_q <= NULL_RUN;
			steps_q <= '0;
		end
		if (cmd.step) begin
			prev_q <= cur_q;
			prev_len_q <= rd_len;
			cur_q <= link;
			steps_q <= steps_q + 17'd1;
		end
		if (cmd.a_commit) begin
			got_q <= (rd_len == need) ? cur_q : (cur_q + rd_len - need);
		end
		if (cmd.f_wp) begin
			pn_q <= wn_d;
			pl_q <= wl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= RST_BLOCK_LOG2;
			hb_q <= RST_HEAP_BLOCKS;
			ft_q <= RST_FIXED_TYPE;
			head_q <= (RST_H == 16'd0) ? NULL_RUN : 16'd0;
			free_q <= RST_H;
			live_q <= '0;
			granted_q <= NULL_RUN;
			for (int i = 0; i < int'(TYPE_COUNT); i++) begin
				tlive_q[i] <= '0;
				tblk_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BLOCK_LOG2: lg_q <= cfg_data[2:0];
				REG_HEAP_BLOCKS: hb_q <= cfg_data;
				REG_FIXED_TYPE: ft_q <= cfg_data[3:0];
				default: ;
			endcase
			if (restart) begin
				head_q <= (h_new == 16'd0) ? NULL_RUN : 16'd0;
				free_q <= h_new;
				live_q <= '0;
				for (int i = 0; i < int'(TYPE_COUNT); i++) begin
					tlive_q[i] <= '0;
					tblk_q[i] <= '0;
				end
			end
		end else begin
			if (cmd.latch) granted_q <= NULL_RUN;
			if (cmd.a_commit) begin
				if ((rd_len == need) && prev_null) head_q <= link;
				granted_q <= (rd_len == need ? cur_q : (cur_q + rd_len - need))
					+ {15'd0, is_fixed};
				free_q <= dec_sat(free_q, need);
				live_q <= inc_sat(live_q, 16'd1);
				tlive_q[tix] <= inc_sat(tlive_q[tix], 16'd1);
				tblk_q[tix] <= inc_sat(tblk_q[tix], need);
			end
			if (cmd.f_wprev) begin
				if (prev_null) head_q <= p;
				free_q <= inc_sat(free_q, flen_q);
				live_q <= dec_sat(live_q, 16'd1);
				tlive_q[tix] <= dec_sat(tlive_q[tix], 16'd1);
				tblk_q[tix] <= dec_sat(tblk_q[tix], flen_q);
			end
		end
	end

	assign granted = granted_q;
	assign free_tot = free_q;
	assign live_tot = live_q;
	assign t_live = type_bad ? 16'd0 : tlive_q[tix];
	assign t_blocks = type_bad ? 16'd0 : tblk_q[tix];

endmodule
`default_nettype wire
